[hdl/tsi_pkg.sv]
// Package for the timer, serial and interrupt unit.
// Holds field widths, command and register codes, flag bits and the
// command/status structs shared by the controller and the datapath.
package tsi_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int SEL_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int RAISE_W = 5;
    localparam int PEND_W  = 3;

    // Internal state widths
    localparam int DACC_W  = 8;   // divider accumulator, always below one period
    localparam int CACC_W  = 10;  // counter accumulator, always below 1024
    localparam int SACC_W  = 10;  // serial accumulator
    localparam int SCNT_W  = 5;   // serial shift count, all ones when idle
    localparam int STEPS_W = 8;   // counter steps left in one tick
    localparam int CSH_W   = 4;   // counter period as a shift amount

    // Commands
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ACK   = 2'd3;

    // Register select codes
    localparam logic [SEL_W-1:0] REG_DIV   = 3'd0;
    localparam logic [SEL_W-1:0] REG_TIMA  = 3'd1;
    localparam logic [SEL_W-1:0] REG_TMA   = 3'd2;
    localparam logic [SEL_W-1:0] REG_TAC   = 3'd3;
    localparam logic [SEL_W-1:0] REG_SB    = 3'd4;
    localparam logic [SEL_W-1:0] REG_SC    = 3'd5;
    localparam logic [SEL_W-1:0] REG_IF    = 3'd6;
    localparam logic [SEL_W-1:0] REG_IE    = 3'd7;

    // Flag bits
    localparam logic [BYTE_W-1:0] FLAG_TIMER  = 8'h04;
    localparam logic [BYTE_W-1:0] FLAG_SERIAL = 8'h08;

    // Serial control bits
    localparam int SC_START  = 7;
    localparam int SC_INTCLK = 0;

    // Serial idle marker
    localparam logic [SCNT_W-1:0] SCNT_IDLE = 5'h1F;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // execute the item on the input channel
        logic step;      // one counter chunk
        logic load_out;  // capture the result into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic steps_left;  // counter steps still to apply
    } t_dp_stat;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

endpackage

[hdl/tsi_if.sv]
// Channel interfaces of the timer, serial and interrupt unit.
// Depends on tsi_pkg for the field widths.
interface tsi_item_if;
    logic                          valid;
    logic                          ready;
    logic [tsi_pkg::CMD_W-1:0]     cmd;
    logic [tsi_pkg::SEL_W-1:0]     reg_sel;
    logic [tsi_pkg::BYTE_W-1:0]    write_data;
    logic [tsi_pkg::BYTE_W-1:0]    cycles;
    logic [tsi_pkg::RAISE_W-1:0]   raise_mask;

    modport source (output valid, cmd, reg_sel, write_data, cycles, raise_mask, input ready);
    modport sink   (input valid, cmd, reg_sel, write_data, cycles, raise_mask, output ready);
endinterface

interface tsi_result_if;
    logic                          valid;
    logic                          ready;
    logic [tsi_pkg::BYTE_W-1:0]    read_data;
    logic [tsi_pkg::BYTE_W-1:0]    int_flags;
    logic [tsi_pkg::PEND_W-1:0]    pending_id;

    modport source (output valid, read_data, int_flags, pending_id, input ready);
    modport sink   (input valid, read_data, int_flags, pending_id, output ready);
endinterface

interface tsi_cfg_if;
    logic valid;
    logic ready;
    logic speed_shift;

    modport source (output valid, speed_shift, input ready);
    modport sink   (input valid, speed_shift, output ready);
endinterface

[hdl/tsi_ctrl.sv]
// Controller of the timer, serial and interrupt unit: item sequencing,
// counter step loop and output register handshake.
// Depends on tsi_pkg.
module tsi_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tsi_pkg::t_dp_cmd   o_cmd,
    input  tsi_pkg::t_dp_stat  i_stat
);

    tsi_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    // Next state and datapath commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        case (r_state)
            tsi_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = tsi_pkg::S_RUN;
                end
            end
            tsi_pkg::S_RUN: begin
                if (i_stat.steps_left) begin
                    o_cmd.step = 1'b1;
                end else if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = tsi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tsi_pkg::S_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsi_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[hdl/tsi_datapath.sv]
// Datapath of the timer, serial and interrupt unit: divider, counter,
// serial shifter, flag/enable registers, bus access and result register.
// Depends on tsi_pkg; driven by tsi_ctrl commands.
module tsi_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsi_pkg::t_dp_cmd              i_cmd,
    output tsi_pkg::t_dp_stat             o_stat,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_speed,
    input  logic [tsi_pkg::CMD_W-1:0]     i_item_cmd,
    input  logic [tsi_pkg::SEL_W-1:0]     i_reg_sel,
    input  logic [tsi_pkg::BYTE_W-1:0]    i_write_data,
    input  logic [tsi_pkg::BYTE_W-1:0]    i_cycles,
    input  logic [tsi_pkg::RAISE_W-1:0]   i_raise_mask,
    output logic [tsi_pkg::BYTE_W-1:0]    o_read_data,
    output logic [tsi_pkg::BYTE_W-1:0]    o_int_flags,
    output logic [tsi_pkg::PEND_W-1:0]    o_pending_id
);

    // Counter period as a shift amount at normal speed
    function automatic logic [tsi_pkg::CSH_W-1:0] count_shift(input logic [1:0] sel);
        logic [tsi_pkg::CSH_W-1:0] sh;
        case (sel)
            2'd0:    sh = 4'd10;
            2'd1:    sh = 4'd4;
            2'd2:    sh = 4'd6;
            default: sh = 4'd8;
        endcase
        return sh;
    endfunction

    // Lowest set request bit, numbered from one
    function automatic logic [tsi_pkg::PEND_W-1:0] pend_id(
        input logic [tsi_pkg::RAISE_W-1:0] m
    );
        logic [tsi_pkg::PEND_W-1:0] id;
        id = '0;
        for (int k = tsi_pkg::RAISE_W - 1; k >= 0; k--) begin
            if (m[k]) begin
                id = tsi_pkg::PEND_W'(k + 1);
            end
        end
        return id;
    endfunction

    // Architectural state
    logic                          r_speed,        n_speed;
    logic [tsi_pkg::DACC_W-1:0]    r_div_accum,    n_div_accum;
    logic [tsi_pkg::BYTE_W-1:0]    r_divider,      n_divider;
    logic [tsi_pkg::CACC_W-1:0]    r_count_accum,  n_count_accum;
    logic [tsi_pkg::BYTE_W-1:0]    r_counter,      n_counter;
    logic [tsi_pkg::BYTE_W-1:0]    r_modulo,       n_modulo;
    logic                          r_timer_on,     n_timer_on;
    logic [1:0]                    r_clock_select, n_clock_select;
    logic [tsi_pkg::SACC_W-1:0]    r_serial_accum, n_serial_accum;
    logic [tsi_pkg::SCNT_W-1:0]    r_shift_count,  n_shift_count;
    logic [tsi_pkg::BYTE_W-1:0]    r_serial_byte,  n_serial_byte;
    logic [tsi_pkg::BYTE_W-1:0]    r_serial_ctrl,  n_serial_ctrl;
    logic [tsi_pkg::BYTE_W-1:0]    r_flag,         n_flag;
    logic [tsi_pkg::BYTE_W-1:0]    r_enable,       n_enable;

    // Per-item working registers and result register
    logic [tsi_pkg::STEPS_W-1:0]   r_steps,        n_steps;
    logic [tsi_pkg::BYTE_W-1:0]    r_rd,           n_rd;
    logic [tsi_pkg::BYTE_W-1:0]    r_out_rd,       n_out_rd;
    logic [tsi_pkg::BYTE_W-1:0]    r_out_flags,    n_out_flags;
    logic [tsi_pkg::PEND_W-1:0]    r_out_pend,     n_out_pend;

    // Intermediate values
    logic [tsi_pkg::DACC_W:0]      div_sum;
    logic [tsi_pkg::CACC_W:0]      cnt_sum;
    logic [tsi_pkg::CACC_W:0]      cnt_mask;
    logic [tsi_pkg::CSH_W-1:0]     cnt_sh;
    logic [tsi_pkg::SACC_W-1:0]    ser_sum;
    logic [tsi_pkg::SACC_W-1:0]    ser_period;
    logic                          ser_active;
    logic [tsi_pkg::RAISE_W-1:0]   pend_bits;
    logic [tsi_pkg::RAISE_W-1:0]   ack_bit;
    logic [tsi_pkg::BYTE_W:0]      gap;
    logic [tsi_pkg::BYTE_W-1:0]    flags_tick;

    // Arithmetic shared by the tick and step paths
    always_comb begin
        div_sum    = {1'b0, r_div_accum} + {1'b0, i_cycles};
        cnt_sum    = {1'b0, r_count_accum} + (tsi_pkg::CACC_W + 1)'(i_cycles);
        cnt_sh     = count_shift(r_clock_select) - tsi_pkg::CSH_W'(r_speed);
        cnt_mask   = ((tsi_pkg::CACC_W + 1)'(1) << cnt_sh) - (tsi_pkg::CACC_W + 1)'(1);
        ser_sum    = r_serial_accum + tsi_pkg::SACC_W'(i_cycles);
        ser_period = r_speed ? 10'd256 : 10'd512;
        ser_active = r_serial_ctrl[tsi_pkg::SC_START] && r_serial_ctrl[tsi_pkg::SC_INTCLK];
        pend_bits  = r_enable[tsi_pkg::RAISE_W-1:0] & r_flag[tsi_pkg::RAISE_W-1:0];
        ack_bit    = pend_bits & (~pend_bits + tsi_pkg::RAISE_W'(1));
        gap        = 9'd256 - {1'b0, r_counter};
    end

    // Next-state logic
    always_comb begin
        n_speed        = r_speed;
        n_div_accum    = r_div_accum;
        n_divider      = r_divider;
        n_count_accum  = r_count_accum;
        n_counter      = r_counter;
        n_modulo       = r_modulo;
        n_timer_on     = r_timer_on;
        n_clock_select = r_clock_select;
        n_serial_accum = r_serial_accum;
        n_shift_count  = r_shift_count;
        n_serial_byte  = r_serial_byte;
        n_serial_ctrl  = r_serial_ctrl;
        n_flag         = r_flag;
        n_enable       = r_enable;
        n_steps        = r_steps;
        n_rd           = r_rd;
        n_out_rd       = r_out_rd;
        n_out_flags    = r_out_flags;
        n_out_pend     = r_out_pend;
        flags_tick     = r_flag | tsi_pkg::BYTE_W'(i_raise_mask);

        if (i_cfg_we) begin
            n_speed = i_cfg_speed;
        end

        if (i_cmd.accept) begin
            n_rd    = '0;
            n_steps = '0;
            case (i_item_cmd)
                tsi_pkg::CMD_TICK: begin
                    // Divider: one increment per full period
                    if (r_speed) begin
                        n_divider   = r_divider + tsi_pkg::BYTE_W'(div_sum[8:7]);
                        n_div_accum = {1'b0, div_sum[6:0]};
                    end else begin
                        n_divider   = r_divider + tsi_pkg::BYTE_W'(div_sum[8]);
                        n_div_accum = div_sum[7:0];
                    end
                    // Counter: steps are applied by the step loop
                    if (r_timer_on) begin
                        n_steps       = tsi_pkg::STEPS_W'(cnt_sum >> cnt_sh);
                        n_count_accum = tsi_pkg::CACC_W'(cnt_sum & cnt_mask);
                    end
                    // Serial shifter
                    if (ser_active) begin
                        n_serial_accum = ser_sum;
                        if (r_shift_count[tsi_pkg::SCNT_W-1]) begin
                            n_shift_count  = '0;
                            n_serial_accum = '0;
                        end else if (ser_sum >= ser_period) begin
                            if (r_shift_count[3]) begin
                                n_serial_ctrl[tsi_pkg::SC_START] = 1'b0;
                                flags_tick    = flags_tick | tsi_pkg::FLAG_SERIAL;
                                n_shift_count = tsi_pkg::SCNT_IDLE;
                            end else begin
                                n_serial_byte  = {r_serial_byte[tsi_pkg::BYTE_W-2:0], 1'b1};
                                n_serial_accum = ser_sum - ser_period;
                                n_shift_count  = r_shift_count + tsi_pkg::SCNT_W'(1);
                            end
                        end
                    end
                    n_flag = flags_tick;
                end
                tsi_pkg::CMD_READ: begin
                    case (i_reg_sel)
                        tsi_pkg::REG_DIV:  n_rd = r_divider;
                        tsi_pkg::REG_TIMA: n_rd = r_counter;
                        tsi_pkg::REG_TMA:  n_rd = r_modulo;
                        tsi_pkg::REG_TAC:  n_rd = {5'b0, r_timer_on, r_clock_select};
                        tsi_pkg::REG_SB:   n_rd = r_serial_byte;
                        tsi_pkg::REG_SC:   n_rd = r_serial_ctrl;
                        tsi_pkg::REG_IF:   n_rd = r_flag;
                        default:           n_rd = r_enable;
                    endcase
                end
                tsi_pkg::CMD_WRITE: begin
                    case (i_reg_sel)
                        tsi_pkg::REG_DIV:  n_divider = '0;
                        tsi_pkg::REG_TIMA: n_counter = i_write_data;
                        tsi_pkg::REG_TMA:  n_modulo  = i_write_data;
                        tsi_pkg::REG_TAC: begin
                            n_timer_on     = i_write_data[2];
                            n_clock_select = i_write_data[1:0];
                            if (!i_write_data[2]) begin
                                n_count_accum = '0;
                            end
                        end
                        tsi_pkg::REG_SB:   n_serial_byte = i_write_data;
                        tsi_pkg::REG_SC:   n_serial_ctrl = i_write_data;
                        tsi_pkg::REG_IF:   n_flag        = i_write_data;
                        default:           n_enable      = i_write_data;
                    endcase
                end
                default: begin
                    // Acknowledge: clear the lowest pending request
                    n_flag = r_flag & ~tsi_pkg::BYTE_W'(ack_bit);
                end
            endcase
        end else if (i_cmd.step) begin
            // Counter chunk: run up to the next overflow or use up the steps
            if ({1'b0, r_steps} < gap) begin
                n_counter = r_counter + r_steps;
                n_steps   = '0;
            end else begin
                n_steps   = tsi_pkg::STEPS_W'({1'b0, r_steps} - gap);
                n_counter = r_modulo;
                n_flag    = r_flag | tsi_pkg::FLAG_TIMER;
            end
        end

        // Result register
        if (i_cmd.load_out) begin
            n_out_rd    = r_rd;
            n_out_flags = r_flag;
            n_out_pend  = pend_id(pend_bits);
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed        <= 1'b0;
            r_div_accum    <= '0;
            r_divider      <= '0;
            r_count_accum  <= '0;
            r_counter      <= '0;
            r_modulo       <= '0;
            r_timer_on     <= 1'b0;
            r_clock_select <= '0;
            r_serial_accum <= '0;
            r_shift_count  <= tsi_pkg::SCNT_IDLE;
            r_serial_byte  <= '0;
            r_serial_ctrl  <= '0;
            r_flag         <= '0;
            r_enable       <= '0;
            r_steps        <= '0;
        end else begin
            r_speed        <= n_speed;
            r_div_accum    <= n_div_accum;
            r_divider      <= n_divider;
            r_count_accum  <= n_count_accum;
            r_counter      <= n_counter;
            r_modulo       <= n_modulo;
            r_timer_on     <= n_timer_on;
            r_clock_select <= n_clock_select;
            r_serial_accum <= n_serial_accum;
            r_shift_count  <= n_shift_count;
            r_serial_byte  <= n_serial_byte;
            r_serial_ctrl  <= n_serial_ctrl;
            r_flag         <= n_flag;
            r_enable       <= n_enable;
            r_steps        <= n_steps;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd        <= n_rd;
        r_out_rd    <= n_out_rd;
        r_out_flags <= n_out_flags;
        r_out_pend  <= n_out_pend;
    end

    assign o_stat.steps_left = (r_steps != '0);
    assign o_read_data       = r_out_rd;
    assign o_int_flags       = r_out_flags;
    assign o_pending_id      = r_out_pend;

endmodule

[hdl/timer_serial_interrupt_unit.sv]
// Top level of the timer, serial and interrupt unit: tsi_ctrl plus tsi_datapath.
// Depends on tsi_pkg, tsi_if, tsi_ctrl and tsi_datapath.
// Sequence: an accepted item is executed, then the counter is advanced one chunk at a time
//   (a chunk runs up to the next overflow or uses up the steps), and the result is then
//   registered once the output register is free; no new item is taken until then.
// Reset: synchronous, active low; state registers to zero, serial shifter and controller idle.
module timer_serial_interrupt_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tsi_item_if.sink     i_item,
    tsi_result_if.source o_result,
    tsi_cfg_if.sink      i_cfg
);

    tsi_pkg::t_dp_cmd  dp_cmd;
    tsi_pkg::t_dp_stat dp_stat;

    // Speed register is always writable
    assign i_cfg.ready = 1'b1;

    tsi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    tsi_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_speed  (i_cfg.speed_shift),
        .i_item_cmd   (i_item.cmd),
        .i_reg_sel    (i_item.reg_sel),
        .i_write_data (i_item.write_data),
        .i_cycles     (i_item.cycles),
        .i_raise_mask (i_item.raise_mask),
        .o_read_data  (o_result.read_data),
        .o_int_flags  (o_result.int_flags),
        .o_pending_id (o_result.pending_id)
    );

endmodule
